/* sv/mlk_pkg.sv */
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared types, codes and the letter table of the Morse letter keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlk_pkg;

   localparam int DEFAULT_MAX_SYMBOLS = 4;
   localparam int DESC_QUEUE_DEPTH    = 2;
   localparam int RSP_QUEUE_DEPTH     = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 10;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_UNIT_TICKS       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DASH_UNITS       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYMBOL_GAP_UNITS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LETTER_GAP_UNITS = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WORD_GAP_UNITS   = 3'd4;

   localparam logic [9:0] RST_UNIT_TICKS       = 10'd64;
   localparam logic [3:0] RST_DASH_UNITS       = 4'd3;
   localparam logic [3:0] RST_SYMBOL_GAP_UNITS = 4'd1;
   localparam logic [3:0] RST_LETTER_GAP_UNITS = 4'd3;
   localparam logic [3:0] RST_WORD_GAP_UNITS   = 4'd7;

   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_Z     = 8'h7a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // character classes
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_LETTER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SPACE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BAD    = 2'd2;

   localparam logic [3:0] DOT_UNITS = 4'd1;

   typedef struct packed {
      logic [9:0] unit_ticks;
      logic [3:0] dash_units;
      logic [3:0] symbol_gap_units;
      logic [3:0] letter_gap_units;
      logic [3:0] word_gap_units;
   } cfg_type;

   typedef struct packed {
      logic        light_on;
      logic [3:0]  units;
      logic [13:0] duration_ticks;
      logic        bad_char;
      logic        last;
   } rsp_type;

   // symbol count of letter a + idx
   function automatic logic [2:0] code_len(input logic [4:0] idx);
      logic [2:0] len;
      unique case (idx)
         5'd0:  len = 3'd2;  5'd1:  len = 3'd4;  5'd2:  len = 3'd4;
         5'd3:  len = 3'd3;  5'd4:  len = 3'd1;  5'd5:  len = 3'd4;
         5'd6:  len = 3'd3;  5'd7:  len = 3'd4;  5'd8:  len = 3'd2;
         5'd9:  len = 3'd4;  5'd10: len = 3'd3;  5'd11: len = 3'd4;
         5'd12: len = 3'd2;  5'd13: len = 3'd2;  5'd14: len = 3'd3;
         5'd15: len = 3'd4;  5'd16: len = 3'd4;  5'd17: len = 3'd3;
         5'd18: len = 3'd3;  5'd19: len = 3'd1;  5'd20: len = 3'd3;
         5'd21: len = 3'd4;  5'd22: len = 3'd3;  5'd23: len = 3'd4;
         5'd24: len = 3'd4;  5'd25: len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // dash mask of letter a + idx, bit i set for a dash at symbol i
   function automatic logic [3:0] code_dash(input logic [4:0] idx);
      logic [3:0] mask;
      unique case (idx)
         5'd0:  mask = 4'd2;  5'd1:  mask = 4'd1;  5'd2:  mask = 4'd5;
         5'd3:  mask = 4'd1;  5'd4:  mask = 4'd0;  5'd5:  mask = 4'd4;
         5'd6:  mask = 4'd3;  5'd7:  mask = 4'd0;  5'd8:  mask = 4'd0;
         5'd9:  mask = 4'd14; 5'd10: mask = 4'd5;  5'd11: mask = 4'd2;
         5'd12: mask = 4'd3;  5'd13: mask = 4'd1;  5'd14: mask = 4'd7;
         5'd15: mask = 4'd6;  5'd16: mask = 4'd11; 5'd17: mask = 4'd2;
         5'd18: mask = 4'd0;  5'd19: mask = 4'd1;  5'd20: mask = 4'd4;
         5'd21: mask = 4'd8;  5'd22: mask = 4'd6;  5'd23: mask = 4'd9;
         5'd24: mask = 4'd13; 5'd25: mask = 4'd3;
         default: mask = 4'd0;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

/* sv/morse_letter_keyer.sv */
// ----------------------------------------------------------------------------
// morse_letter_keyer
// Turns one character into the on/off light segments of its Morse code.
// ----------------------------------------------------------------------------
//  channel   ports                         direction   transfer when
//  req       req_push/req_full/character   in          req_push && !req_full
//  rsp       rsp_pop/rsp_empty/fields      out         rsp_pop && !rsp_empty
//  csr       csr_we/csr_addr/csr_wdata     in          csr_we
//
//  a letter of n symbols gives 2n+1 segments, a space or bad byte gives one;
//  the back sequencer emits one segment per cycle while the result queue has
//  room, a letter holds it for all its segments and the next character starts
//  in the following cycle; a first segment passes both queues before it shows
//  reset clears both queues, the sequencer and loads register defaults
//  req_full rises when the descriptor queue is full; rsp_pop low stalls
//  the sequencer through the result queue
// ----------------------------------------------------------------------------
`default_nettype none

module morse_letter_keyer #(
   parameter int MAX_SYMBOLS = mlk_pkg::DEFAULT_MAX_SYMBOLS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [7:0]                     req_character,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic                                rsp_light_on,
   output logic      [3:0]                     rsp_units,
   output logic      [13:0]                    rsp_duration_ticks,
   output logic                                rsp_bad_char,
   output logic                                rsp_last,
   input  wire logic                           csr_we,
   input  wire logic [mlk_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [mlk_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import mlk_pkg::*;

   localparam int LW = $clog2(MAX_SYMBOLS + 1);

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [LW-1:0]          len;
      logic [MAX_SYMBOLS-1:0] mask;
   } desc_type;

   cfg_type  cfg_ff, cfg_in;
   desc_type front_desc, back_desc;
   logic     desc_empty, desc_pop;
   rsp_type  seg, rsp;
   logic     seg_push, seg_full;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_UNIT_TICKS:       cfg_in.unit_ticks       = csr_wdata[9:0];
            CSR_DASH_UNITS:       cfg_in.dash_units       = csr_wdata[3:0];
            CSR_SYMBOL_GAP_UNITS: cfg_in.symbol_gap_units = csr_wdata[3:0];
            CSR_LETTER_GAP_UNITS: cfg_in.letter_gap_units = csr_wdata[3:0];
            CSR_WORD_GAP_UNITS:   cfg_in.word_gap_units   = csr_wdata[3:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_ticks       <= RST_UNIT_TICKS;
         cfg_ff.dash_units       <= RST_DASH_UNITS;
         cfg_ff.symbol_gap_units <= RST_SYMBOL_GAP_UNITS;
         cfg_ff.letter_gap_units <= RST_LETTER_GAP_UNITS;
         cfg_ff.word_gap_units   <= RST_WORD_GAP_UNITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mlk_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .LW          (LW)
   ) u_front (
      .req_character (req_character),
      .desc_kind     (front_desc.kind),
      .desc_len      (front_desc.len),
      .desc_mask     (front_desc.mask)
   );

   mlk_queue #(
      .WIDTH ($bits(desc_type)),
      .DEPTH (DESC_QUEUE_DEPTH)
   ) u_desc_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .data_in  (front_desc),
      .full     (req_full),
      .pop      (desc_pop),
      .data_out (back_desc),
      .empty    (desc_empty)
   );

   mlk_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .LW          (LW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .desc_valid (!desc_empty),
      .desc_kind  (back_desc.kind),
      .desc_len   (back_desc.len),
      .desc_mask  (back_desc.mask),
      .desc_pop   (desc_pop),
      .seg_full   (seg_full),
      .seg_push   (seg_push),
      .seg        (seg)
   );

   mlk_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (seg_push),
      .data_in  (seg),
      .full     (seg_full),
      .pop      (rsp_pop),
      .data_out (rsp),
      .empty    (rsp_empty)
   );

   assign rsp_light_on       = rsp.light_on;
   assign rsp_units          = rsp.units;
   assign rsp_duration_ticks = rsp.duration_ticks;
   assign rsp_bad_char       = rsp.bad_char;
   assign rsp_last           = rsp.last;

endmodule

`default_nettype wire

/* sv/mlk_queue.sv */
// ----------------------------------------------------------------------------
// mlk_queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module mlk_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] data_in,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] data_out,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

`default_nettype wire

/* sv/mlk_front.sv */
// ----------------------------------------------------------------------------
// mlk_front
// Classifies a character and looks up its symbol count and dash mask.
// ----------------------------------------------------------------------------
`default_nettype none

module mlk_front #(
   parameter int MAX_SYMBOLS = 4,
   parameter int LW          = $clog2(MAX_SYMBOLS + 1)
) (
   input  wire logic [7:0]                 req_character,
   output logic      [mlk_pkg::KIND_W-1:0] desc_kind,
   output logic      [LW-1:0]              desc_len,
   output logic      [MAX_SYMBOLS-1:0]     desc_mask
);

   import mlk_pkg::*;

   logic [4:0] letter_idx;
   logic       is_letter;

   assign letter_idx = 5'(req_character - CHAR_A);
   assign is_letter  = (req_character >= CHAR_A) && (req_character <= CHAR_Z);

   always_comb begin
      desc_len  = '0;
      desc_mask = '0;
      if (req_character == CHAR_SPACE) begin
         desc_kind = KIND_SPACE;
      end else if (is_letter) begin
         desc_kind = KIND_LETTER;
         desc_len  = LW'(code_len(letter_idx));
         desc_mask = MAX_SYMBOLS'(code_dash(letter_idx));
      end else begin
         desc_kind = KIND_BAD;
      end
   end

endmodule

`default_nettype wire

/* sv/mlk_back.sv */
// ----------------------------------------------------------------------------
// mlk_back
// Segment sequencer: walks one descriptor, one segment per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mlk_back #(
   parameter int MAX_SYMBOLS = 4,
   parameter int LW          = $clog2(MAX_SYMBOLS + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mlk_pkg::cfg_type                cfg,
   input  wire logic                            desc_valid,
   input  wire logic [mlk_pkg::KIND_W-1:0]      desc_kind,
   input  wire logic [LW-1:0]                   desc_len,
   input  wire logic [MAX_SYMBOLS-1:0]          desc_mask,
   output logic                                 desc_pop,
   input  wire logic                            seg_full,
   output logic                                 seg_push,
   output mlk_pkg::rsp_type                     seg
);

   import mlk_pkg::*;

   localparam int SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

   logic [LW-1:0] sym_ff, sym_in;
   logic          gap_ff, gap_in;
   logic [SW-1:0] sym_idx;
   logic [3:0]    seg_units;

   assign sym_idx  = sym_ff[SW-1:0];
   assign seg_push = desc_valid && !seg_full;
   assign desc_pop = seg_push && seg.last;

   always_comb begin
      seg.light_on = 1'b0;
      seg.bad_char = 1'b0;
      seg.last     = 1'b0;
      seg_units    = '0;
      unique case (desc_kind)
         KIND_SPACE: begin
            seg_units = cfg.word_gap_units;
            seg.last  = 1'b1;
         end
         KIND_LETTER: begin
            if (sym_ff == desc_len) begin
               seg_units = cfg.letter_gap_units;
               seg.last  = 1'b1;
            end else if (!gap_ff) begin
               seg.light_on = 1'b1;
               seg_units    = desc_mask[sym_idx] ? cfg.dash_units : DOT_UNITS;
            end else begin
               seg_units = cfg.symbol_gap_units;
            end
         end
         default: begin
            seg.bad_char = 1'b1;
            seg.last     = 1'b1;
         end
      endcase
      seg.units          = seg_units;
      seg.duration_ticks = 14'(seg_units) * 14'(cfg.unit_ticks);
   end

   always_comb begin
      sym_in = sym_ff;
      gap_in = gap_ff;
      if (seg_push) begin
         if (seg.last) begin
            sym_in = '0;
            gap_in = 1'b0;
         end else if (!gap_ff) begin
            gap_in = 1'b1;
         end else begin
            gap_in = 1'b0;
            sym_in = sym_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= '0;
         gap_ff <= 1'b0;
      end else begin
         sym_ff <= sym_in;
         gap_ff <= gap_in;
      end
   end

endmodule

`default_nettype wire

/* sv/mlk_checker.sv */
// ----------------------------------------------------------------------------
// mlk_checker
// Port-level checks of the Morse letter keyer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlk_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic        rsp_light_on,
   input wire logic [3:0]  rsp_units,
   input wire logic [13:0] rsp_duration_ticks,
   input wire logic        rsp_bad_char,
   input wire logic        rsp_last
);

   // nothing waits right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result waiting after reset");

   // a bad character gives one dark zero-length segment
   a_bad_char_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_bad_char) |->
         (rsp_last && !rsp_light_on && rsp_units == 4'd0 &&
          rsp_duration_ticks == 14'd0))
      else $error("bad character segment malformed");

   // every letter ends on a dark gap
   a_on_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_light_on) |-> !rsp_last)
      else $error("light on for last segment");

   // zero units means zero ticks
   a_zero_ticks: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_units == 4'd0) |-> rsp_duration_ticks == 14'd0)
      else $error("ticks without units");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_light_on) && $stable(rsp_units) &&
          $stable(rsp_duration_ticks) && $stable(rsp_bad_char) &&
          $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind morse_letter_keyer mlk_checker u_mlk_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_light_on       (rsp_light_on),
   .rsp_units          (rsp_units),
   .rsp_duration_ticks (rsp_duration_ticks),
   .rsp_bad_char       (rsp_bad_char),
   .rsp_last           (rsp_last)
);

`default_nettype wire

/* test/morse_letter_keyer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse_letter_keyer_tb
// Feeds characters into the Morse letter keyer under several register
// settings, keeps its own model of the letter table and the segment timing,
// and compares every segment transfer on the result side against it.
// ----------------------------------------------------------------------------

module morse_letter_keyer_tb;
   import mlk_pkg::*;

   localparam int HALF_PERIOD     = 2;
   localparam int RESET_CYCLES    = 7;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int SETTING_PHASES  = 7;
   localparam int CHARS_PER_PHASE = 64;
   localparam int N_DIRECTED      = 21;
   localparam int MAX_REPORTED    = 10;
   localparam int DRAIN_CYCLES    = 16;

   localparam rsp_type BAD_SEGMENT    = '{1'b0, 4'd0, 14'd0, 1'b1, 1'b1};
   localparam rsp_type SPACE_AT_RESET = '{1'b0, 4'd7, 14'd448, 1'b0, 1'b1};
   localparam rsp_type NO_SEGMENT     = '0;

   typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_EVERY_FIFTH} pop_mode_type;

   typedef struct packed {
      logic [7:0] character;
      logic       typed;
      rsp_type    seg;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [7:0]            req_character;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic                  rsp_light_on;
   logic [3:0]            rsp_units;
   logic [13:0]           rsp_duration_ticks;
   logic                  rsp_bad_char;
   logic                  rsp_last;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cfg_type key_cfg;
   rsp_type pending_segments[$];
   int      burst_left;
   int      cycle_count;
   int      n_letters;
   int      n_spaces;
   int      n_bad;
   int      n_checked;
   int      n_fail;
   int      n_settings;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{CHAR_SPACE, 1'b1, SPACE_AT_RESET},
      '{8'h00, 1'b1, BAD_SEGMENT},
      '{8'hff, 1'b1, BAD_SEGMENT},
      '{8'h60, 1'b1, BAD_SEGMENT},
      '{8'h7b, 1'b1, BAD_SEGMENT},
      '{8'h41, 1'b1, BAD_SEGMENT},
      '{8'h5a, 1'b1, BAD_SEGMENT},
      '{8'h21, 1'b1, BAD_SEGMENT},
      '{8'h1f, 1'b1, BAD_SEGMENT},
      '{8'h80, 1'b1, BAD_SEGMENT},
      '{8'h30, 1'b1, BAD_SEGMENT},
      '{"a", 1'b0, NO_SEGMENT},
      '{"z", 1'b0, NO_SEGMENT},
      '{"e", 1'b0, NO_SEGMENT},
      '{"t", 1'b0, NO_SEGMENT},
      '{"h", 1'b0, NO_SEGMENT},
      '{"o", 1'b0, NO_SEGMENT},
      '{CHAR_SPACE, 1'b0, NO_SEGMENT},
      '{"j", 1'b0, NO_SEGMENT},
      '{"q", 1'b0, NO_SEGMENT},
      '{"y", 1'b0, NO_SEGMENT}
   };

   morse_letter_keyer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_character      (req_character),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_light_on       (rsp_light_on),
      .rsp_units          (rsp_units),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_bad_char       (rsp_bad_char),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic string morse_of(input logic [7:0] c);
      case (c)
         "a": return ".-";    "b": return "-...";  "c": return "-.-.";
         "d": return "-..";   "e": return ".";     "f": return "..-.";
         "g": return "--.";   "h": return "....";  "i": return "..";
         "j": return ".---";  "k": return "-.-";   "l": return ".-..";
         "m": return "--";    "n": return "-.";    "o": return "---";
         "p": return ".--.";  "q": return "--.-";  "r": return ".-.";
         "s": return "...";   "t": return "-";     "u": return "..-";
         "v": return "...-";  "w": return ".--";   "x": return "-..-";
         "y": return "-.--";  "z": return "--..";
         default: return "";
      endcase
   endfunction

   function automatic rsp_type make_segment(input logic on, input logic [3:0] units,
                                            input logic bad, input logic last);
      rsp_type s;
      s.light_on       = on;
      s.units          = units;
      s.duration_ticks = 14'(units) * 14'(key_cfg.unit_ticks);
      s.bad_char       = bad;
      s.last           = last;
      return s;
   endfunction

   // expected segments of one character, appended in emission order
   function automatic void key_character(input logic [7:0] c);
      string pattern;
      if (c == CHAR_SPACE) begin
         pending_segments.push_back(make_segment(1'b0, key_cfg.word_gap_units, 1'b0, 1'b1));
      end else if (c < CHAR_A || c > CHAR_Z) begin
         pending_segments.push_back(make_segment(1'b0, 4'd0, 1'b1, 1'b1));
      end else begin
         pattern = morse_of(c);
         for (int i = 0; i < pattern.len() && i < DEFAULT_MAX_SYMBOLS; i++) begin
            pending_segments.push_back(make_segment(1'b1,
               (pattern[i] == "-") ? key_cfg.dash_units : DOT_UNITS, 1'b0, 1'b0));
            pending_segments.push_back(make_segment(1'b0, key_cfg.symbol_gap_units,
                                                    1'b0, 1'b0));
         end
         pending_segments.push_back(make_segment(1'b0, key_cfg.letter_gap_units, 1'b0, 1'b1));
      end
   endfunction

   function automatic string segment_text(input rsp_type s);
      return $sformatf("on=%0b units=%0d ticks=%0d bad=%0b last=%0b",
                       s.light_on, s.units, s.duration_ticks, s.bad_char, s.last);
   endfunction

   function automatic logic [7:0] random_character();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 62) return CHAR_A + 8'($urandom_range(0, 25));
      if (pick < 77) return CHAR_SPACE;
      return 8'($urandom_range(0, 255));
   endfunction

   // called at a falling edge, returns at a falling edge with csr_we still high
   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      case (index)
         CSR_UNIT_TICKS:       key_cfg.unit_ticks       = value;
         CSR_DASH_UNITS:       key_cfg.dash_units       = value[3:0];
         CSR_SYMBOL_GAP_UNITS: key_cfg.symbol_gap_units = value[3:0];
         CSR_LETTER_GAP_UNITS: key_cfg.letter_gap_units = value[3:0];
         CSR_WORD_GAP_UNITS:   key_cfg.word_gap_units   = value[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] ticks, dash, sym_gap,
                                 letter_gap, word_gap);
      write_register(CSR_UNIT_TICKS, ticks);
      write_register(CSR_DASH_UNITS, dash);
      write_register(CSR_SYMBOL_GAP_UNITS, sym_gap);
      write_register(CSR_LETTER_GAP_UNITS, letter_gap);
      write_register(CSR_WORD_GAP_UNITS, word_gap);
      // unmapped index, must be ignored
      write_register(CSR_WORD_GAP_UNITS + CSR_ADDR_W'($urandom_range(1, 3)),
                     CSR_DATA_W'($urandom_range(0, 1023)));
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_character(input logic [7:0] c, input logic typed,
                                 input rsp_type seg);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_push      <= 1'b1;
      req_character <= c;
      do @(posedge clock); while (req_full);
      if (typed) pending_segments.push_back(seg);
      else key_character(c);
      if (c == CHAR_SPACE) n_spaces++;
      else if (c >= CHAR_A && c <= CHAR_Z) n_letters++;
      else n_bad++;
      @(negedge clock);
   endtask

   task automatic drain_segments();
      req_push   <= 1'b0;
      burst_left  = 0;
      while (pending_segments.size() != 0) @(negedge clock);
   endtask

   initial begin : receiver
      pop_mode_type mode;
      int           span;
      int           tick;
      rsp_pop = 1'b0;
      tick    = 0;
      forever begin
         mode = pop_mode_type'($urandom_range(0, 3));
         span = $urandom_range(8, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               POP_ALWAYS:  rsp_pop <= 1'b1;
               POP_MOSTLY:  rsp_pop <= ($urandom_range(0, 3) != 0);
               POP_RARELY:  rsp_pop <= ($urandom_range(0, 3) == 0);
               default:     rsp_pop <= (tick % 5 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_segments
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_light_on, rsp_units, rsp_duration_ticks, rsp_bad_char, rsp_last};
         if (pending_segments.size() == 0) begin
            n_fail++;
            if (n_fail <= MAX_REPORTED)
               $display("unexpected segment transfer: %s", segment_text(got));
         end else begin
            want = pending_segments.pop_front();
            n_checked++;
            if (got.light_on !== want.light_on || got.units !== want.units ||
                got.duration_ticks !== want.duration_ticks ||
                got.bad_char !== want.bad_char || got.last !== want.last) begin
               n_fail++;
               if (n_fail <= MAX_REPORTED)
                  $display("segment mismatch at cycle %0d: expected %s, got %s",
                           cycle_count, segment_text(want), segment_text(got));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d segments outstanding",
                  cycle_count, pending_segments.size());
         $display("morse_letter_keyer_tb: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      reset         = 1'b1;
      req_push      = 1'b0;
      req_character = 8'h00;
      csr_we        = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      burst_left    = 0;
      cycle_count   = 0;
      n_letters     = 0;
      n_spaces      = 0;
      n_bad         = 0;
      n_checked     = 0;
      n_fail        = 0;
      n_settings    = 1;
      key_cfg = '{RST_UNIT_TICKS, RST_DASH_UNITS, RST_SYMBOL_GAP_UNITS,
                  RST_LETTER_GAP_UNITS, RST_WORD_GAP_UNITS};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults
      for (int i = 0; i < N_DIRECTED; i++)
         send_character(directed_rows[i].character, directed_rows[i].typed,
                        directed_rows[i].seg);
      drain_segments();

      for (int p = 0; p < SETTING_PHASES; p++) begin
         case (p)
            0: apply_settings(10'd1023, 10'd15, 10'd15, 10'd15, 10'd15);
            1: apply_settings(10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
            2: apply_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
            // upper data bits dropped on the 4-bit registers
            3: apply_settings(10'd517, 10'h3f6, 10'h2c2, 10'h159, 10'h0fe);
            6: apply_settings(CSR_DATA_W'($urandom_range(0, 1023)),
                              CSR_DATA_W'($urandom_range(0, 1023)),
                              CSR_DATA_W'($urandom_range(0, 1023)),
                              CSR_DATA_W'($urandom_range(0, 1023)),
                              CSR_DATA_W'($urandom_range(0, 1023)));
            default: apply_settings(CSR_DATA_W'($urandom_range(1, 1023)),
                                    CSR_DATA_W'($urandom_range(1, 15)),
                                    CSR_DATA_W'($urandom_range(1, 15)),
                                    CSR_DATA_W'($urandom_range(1, 15)),
                                    CSR_DATA_W'($urandom_range(1, 15)));
         endcase
         repeat (CHARS_PER_PHASE) send_character(random_character(), 1'b0, NO_SEGMENT);
         drain_segments();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d letters, %0d spaces and %0d invalid bytes under %0d settings",
               n_letters, n_spaces, n_bad, n_settings);
      $display("%0d segments checked, %0d failures, %0d cycles",
               n_checked, n_fail, cycle_count);
      if (n_fail == 0 && pending_segments.size() == 0) begin
         $display("morse_letter_keyer_tb: PASS");
      end else begin
         $display("morse_letter_keyer_tb: FAIL");
      end
      $finish;
   end

endmodule
